// ----- design/lwto_pkg.sv -----
// Shared types and constants for the longest-window-with-target-ones core.
// Used by lwto_stage, lwto_table and longest_window_with_target_ones_core.
`default_nettype none

package lwto_pkg;

    localparam int MAX_LENGTH = 1024;
    localparam int FIELD_W    = 11;
    // entry 0 of the first-position table is always 0 and is not stored
    localparam int TABLE_DEPTH = MAX_LENGTH;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic REG_TARGET_ONES = 1'b0;

    typedef struct packed {
        logic               wr_en;
        logic [IDX_W-1:0]   wr_idx;
        logic [FIELD_W-1:0] wr_data;
        logic               rd_en;
        logic [IDX_W-1:0]   rd_idx;
    } mem_req_t;

    typedef struct packed {
        logic               eval;
        logic               zero_sel;
        logic               fwd;
        logic               last;
        logic [FIELD_W-1:0] pos;
        logic [FIELD_W-1:0] ones;
    } stage_t;

endpackage

`default_nettype wire

// ----- design/lwto_table.sv -----
// First-position table: one write port, one read port, registered read data.
// Depends on lwto_pkg.
`default_nettype none

module lwto_table (
    input  wire logic                       clk,
    input  wire lwto_pkg::mem_req_t         req,
    output logic [lwto_pkg::FIELD_W-1:0]    rd_data
);
    import lwto_pkg::*;

    logic [FIELD_W-1:0] mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_idx] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_idx];
        end
    end

endmodule

`default_nettype wire

// ----- design/lwto_stage.sv -----
// Front stage: running ones count and position, table write and lookup address.
// Depends on lwto_pkg.
`default_nettype none

module lwto_stage (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic                          bit_value,
    input  wire logic                          last_item,
    input  wire logic [lwto_pkg::FIELD_W-1:0]  target,
    output lwto_pkg::mem_req_t                 req,
    output lwto_pkg::stage_t                   info
);
    import lwto_pkg::*;

    logic [FIELD_W-1:0] ones_reg, ones_next;
    logic [FIELD_W-1:0] pos_reg, pos_next;
    logic               counted;
    logic [FIELD_W-1:0] new_pos;
    logic [FIELD_W-1:0] new_ones;
    logic [FIELD_W-1:0] eff_pos;
    logic [FIELD_W-1:0] eff_ones;
    logic [FIELD_W-1:0] rd_addr;
    logic [FIELD_W-1:0] wr_addr;

    always_comb
    begin
        counted  = (pos_reg < FIELD_W'(MAX_LENGTH));
        new_pos  = pos_reg + FIELD_W'(1);
        new_ones = ones_reg + FIELD_W'(bit_value);
        eff_pos  = counted ? new_pos : pos_reg;
        eff_ones = counted ? new_ones : ones_reg;
        rd_addr  = new_ones - target;
        wr_addr  = new_ones - FIELD_W'(1);

        req.wr_en   = accept && counted && bit_value;
        req.wr_idx  = wr_addr[IDX_W-1:0];
        req.wr_data = new_pos;
        req.rd_en   = accept;
        req.rd_idx  = rd_addr[IDX_W-1:0] - IDX_W'(1);

        info.eval     = counted && (new_ones >= target);
        info.zero_sel = (rd_addr == '0);
        // same-cycle write to the looked-up entry: window starts here, length 0
        info.fwd      = bit_value && (target == '0);
        info.last     = last_item;
        info.pos      = eff_pos;
        info.ones     = eff_ones;

        ones_next = ones_reg;
        pos_next  = pos_reg;
        if (accept)
        begin
            ones_next = last_item ? '0 : eff_ones;
            pos_next  = last_item ? '0 : eff_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ones_reg <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            ones_reg <= ones_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/longest_window_with_target_ones_core.sv -----
// Longest window with target ones: top level.
// Takes one word per cycle while in_stall is low; out_valid rises once the last word
// has left s1. Two pipeline stages around the table read (registered read data); input
// stalls only while a final word waits behind a full, stalled output register.
// Reset clears counters, best length, target and the valid flags; table contents are
// left as is since entry 0 is implied and other entries are written before being read.
`default_nettype none

module longest_window_with_target_ones_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lwto_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [lwto_pkg::DATA_W-1:0]   pwdata,
    output logic [lwto_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          bit_value,
    input  wire logic                          last_item,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [lwto_pkg::FIELD_W-1:0]       removals,
    output logic                               impossible
);
    import lwto_pkg::*;

    logic [FIELD_W-1:0] target_reg, target_next;
    logic               s1_valid_reg, s1_valid_next;
    stage_t             s1_reg, s1_next;
    logic [FIELD_W-1:0] best_reg, best_next;
    logic               out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0] removals_reg, removals_next;
    logic               impossible_reg, impossible_next;

    logic               accept;
    logic               s1_hold;
    logic               s1_retire;
    mem_req_t           req;
    stage_t             info;
    logic [FIELD_W-1:0] rd_data;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] len;
    logic [FIELD_W-1:0] best_cand;

    lwto_stage u_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .bit_value (bit_value),
        .last_item (last_item),
        .target    (target_reg),
        .req       (req),
        .info      (info)
    );

    lwto_table u_table (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    // config port
    always_comb
    begin
        pready      = 1'b1;
        target_next = target_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_TARGET_ONES))
        begin
            target_next = pwdata[FIELD_W-1:0];
        end
        prdata = '0;
        if (paddr[2] == REG_TARGET_ONES)
        begin
            prdata = DATA_W'(target_reg);
        end
    end

    always_comb
    begin
        // a final word stuck behind a full, stalled output holds the pipe
        s1_hold   = s1_valid_reg && s1_reg.last && out_valid_reg && out_stall;
        in_stall  = s1_hold;
        accept    = in_valid && !in_stall;
        s1_retire = s1_valid_reg && !s1_hold;

        s1_valid_next = accept ? 1'b1 : s1_hold;
        s1_next       = accept ? info : s1_reg;

        if (s1_reg.zero_sel)
        begin
            start = '0;
        end
        else if (s1_reg.fwd)
        begin
            start = s1_reg.pos;
        end
        else
        begin
            start = rd_data;
        end
        len       = s1_reg.pos - start;
        best_cand = (s1_reg.eval && (len > best_reg)) ? len : best_reg;

        best_next       = best_reg;
        out_valid_next  = out_valid_reg && out_stall;
        removals_next   = removals_reg;
        impossible_next = impossible_reg;
        if (s1_retire)
        begin
            best_next = s1_reg.last ? '0 : best_cand;
            if (s1_reg.last)
            begin
                out_valid_next = 1'b1;
                if (s1_reg.ones < target_reg)
                begin
                    removals_next   = '0;
                    impossible_next = 1'b1;
                end
                else
                begin
                    removals_next   = s1_reg.pos - best_cand;
                    impossible_next = 1'b0;
                end
            end
        end

        out_valid  = out_valid_reg;
        removals   = removals_reg;
        impossible = impossible_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            target_reg    <= target_next;
            s1_valid_reg  <= s1_valid_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg         <= s1_next;
        removals_reg   <= removals_next;
        impossible_reg <= impossible_next;
    end

endmodule

`default_nettype wire
